>>> rtl/lthc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lthc_pkg
// Shared types and constants of the lidar terrain hazard classifier.
// ----------------------------------------------------------------------------
package lthc_pkg;

    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 14;
    localparam int HALF_W  = 12;
    localparam int FRAC_W  = 9;
    localparam int CONF_W  = 8;
    localparam int CFG_W   = 16;
    localparam int QUOT_W  = 9;

    localparam logic [FRAC_W-1:0]  Q8_ONE      = 9'd256;
    localparam logic signed [15:0] TWO_PI_MRAD = 16'sd6283;

    typedef enum logic [2:0] {
        HZ_NONE        = 3'd0,
        HZ_NO_RETURN   = 3'd1,
        HZ_DROP_OFF    = 3'd2,
        HZ_OBSTRUCTION = 3'd3,
        HZ_ROUGH       = 3'd4
    } t_hazard;

    typedef enum logic [2:0] {
        DS_COV  = 3'd0,
        DS_FAR  = 3'd1,
        DS_NEAR = 3'd2,
        DS_C1   = 3'd3,
        DS_C2   = 3'd4
    } t_div_sel;

    typedef enum logic [2:0] {
        CFG_FWD_HALF  = 3'd0,
        CFG_DROP_OFF  = 3'd1,
        CFG_NEAR      = 3'd2,
        CFG_JUMP      = 3'd3,
        CFG_ROUGH     = 3'd4,
        CFG_HAZ_FRAC  = 3'd5,
        CFG_MIN_VALID = 3'd6,
        CFG_CONFIRM   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic     take;
        logic     prep;
        logic     prep2;
        logic     classify;
        logic     div_start;
        t_div_sel div_sel;
        logic     sqrt_start;
        logic     update;
    } t_cmd;

    typedef struct packed {
        t_hazard kind;
        logic    div_done;
        logic    sqrt_done;
    } t_stat;

endpackage

>>> rtl/lthc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lthc_ctrl
// Controller: sequences sample intake, end-of-scan math and result hand-off.
// ----------------------------------------------------------------------------
module lthc_ctrl
    import lthc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_s_tlast,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_tready,
    output logic  o_m_tvalid
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_PREP   = 12'b000000000010,
        ST_PREP2  = 12'b000000000100,
        ST_CLASS  = 12'b000000001000,
        ST_W_COV  = 12'b000000010000,
        ST_W_CONF = 12'b000000100000,
        ST_W_SQRT = 12'b000001000000,
        ST_C1S    = 12'b000010000000,
        ST_W_C1   = 12'b000100000000,
        ST_W_C2   = 12'b001000000000,
        ST_UPD    = 12'b010000000000,
        ST_OUT    = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (i_s_tlast) n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_PREP2;
            end
            ST_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = ST_CLASS;
            end
            ST_CLASS: begin
                o_cmd.classify  = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_COV;
                n_state         = ST_W_COV;
            end
            ST_W_COV: begin
                if (i_stat.div_done) begin
                    case (i_stat.kind)
                        HZ_DROP_OFF: begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DS_FAR;
                            n_state         = ST_W_CONF;
                        end
                        HZ_OBSTRUCTION: begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DS_NEAR;
                            n_state         = ST_W_CONF;
                        end
                        HZ_ROUGH: begin
                            o_cmd.sqrt_start = 1'b1;
                            n_state          = ST_W_SQRT;
                        end
                        default: n_state = ST_UPD;
                    endcase
                end
            end
            ST_W_CONF: begin
                if (i_stat.div_done) n_state = ST_UPD;
            end
            ST_W_SQRT: begin
                if (i_stat.sqrt_done) n_state = ST_C1S;
            end
            ST_C1S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_C1;
                n_state         = ST_W_C1;
            end
            ST_W_C1: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_C2;
                    n_state         = ST_W_C2;
                end
            end
            ST_W_C2: begin
                if (i_stat.div_done) n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/lthc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lthc_dpath
// Datapath: settings, scan accumulators, products, divider, square root.
// ----------------------------------------------------------------------------
module lthc_dpath
    import lthc_pkg::*;
#(
    parameter int MAX_SAMPLES    = 2048,
    parameter int MIN_RANGE_MM   = 100,
    parameter int MAX_RANGE_MM   = 12000,
    parameter int CLR_SCAN_LIMIT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [31:0]       i_s_tdata,
    input  logic              i_s_present,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output t_stat             o_stat,
    output logic [39:0]       o_m_tdata
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = RANGE_W + CW;
    localparam int SQW   = 2 * RANGE_W + CW;
    localparam int DEVW  = 2 * SUMW;
    localparam int LOW   = SQW / 2;
    localparam int HIW   = SQW - LOW;
    localparam int PRNW  = CW + RANGE_W;
    localparam int PFW   = CW + FRAC_W;
    localparam int XW    = PRNW + QUOT_W;

    // Settings.
    logic [HALF_W-1:0]  r_fha;
    logic [RANGE_W-1:0] r_drop, r_near_thr, r_jump_thr, r_rt;
    logic [FRAC_W-1:0]  r_hf, r_mvf;
    logic [CONF_W-1:0]  r_confirm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fha      <= 12'd610;
            r_drop     <= 16'd6000;
            r_near_thr <= 16'd350;
            r_jump_thr <= 16'd1000;
            r_rt       <= 16'd350;
            r_hf       <= 9'd64;
            r_mvf      <= 9'd128;
            r_confirm  <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FWD_HALF:  r_fha      <= i_cfg_wdata[HALF_W-1:0];
                CFG_DROP_OFF:  r_drop     <= i_cfg_wdata;
                CFG_NEAR:      r_near_thr <= i_cfg_wdata;
                CFG_JUMP:      r_jump_thr <= i_cfg_wdata;
                CFG_ROUGH:     r_rt       <= i_cfg_wdata;
                CFG_HAZ_FRAC:  r_hf       <= i_cfg_wdata[FRAC_W-1:0];
                CFG_MIN_VALID: r_mvf      <= i_cfg_wdata[FRAC_W-1:0];
                CFG_CONFIRM:   r_confirm  <= i_cfg_wdata[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample intake.
    logic [RANGE_W-1:0]        s_range;
    logic                      s_finite;
    logic signed [ANGLE_W-1:0] s_angle;
    logic signed [15:0]        a_ext, a_abs, a_alt, a_wrap;
    logic                      in_window, in_range, is_jump;
    logic [RANGE_W-1:0]        step;
    logic [2*RANGE_W-1:0]      r_sq_term;

    logic [CW-1:0]      r_win, r_valid, r_far, r_nearc, r_jump;
    logic [RANGE_W-1:0] r_prev, r_nearest;
    logic               r_have_prev;
    logic [SUMW-1:0]    r_sum;
    logic [SQW-1:0]     r_sumsq;

    assign s_range  = i_s_tdata[15:0];
    assign s_finite = i_s_tdata[16];
    assign s_angle  = i_s_tdata[30:17];

    always_comb begin
        a_ext     = 16'(s_angle);
        a_abs     = (a_ext < 0) ? -a_ext : a_ext;
        a_alt     = TWO_PI_MRAD - a_abs;
        a_wrap    = (a_alt < a_abs) ? a_alt : a_abs;
        in_window = !(a_wrap > $signed({4'b0, r_fha}))
                    && (r_win < CW'(MAX_SAMPLES));
        in_range  = s_finite && (s_range >= RANGE_W'(MIN_RANGE_MM))
                    && (s_range <= RANGE_W'(MAX_RANGE_MM));
        step      = (s_range > r_prev) ? s_range - r_prev : r_prev - s_range;
        is_jump   = r_have_prev && (step >= r_jump_thr);
        r_sq_term = s_range * s_range;
    end

    // End-of-scan products, classification and result registers.
    logic [CW+LOW-1:0] r_plo;
    logic [CW+HIW-1:0] r_phi;
    logic [DEVW-1:0]   r_pss, r_dev, r_prn2;
    logic [PRNW-1:0]   r_prn;
    logic [PFW-1:0]    r_pmvf, r_phfw, r_phfd;
    logic [CW-1:0]     den_n;
    t_hazard           r_kind, n_kind;
    logic [PFW-1:0]    n_sh, f_sh, nr_sh, j_sh;

    assign den_n = (r_valid > CW'(1)) ? r_valid - CW'(1) : CW'(1);
    assign n_sh  = {1'b0, r_valid, 8'b0};
    assign f_sh  = {1'b0, r_far, 8'b0};
    assign nr_sh = {1'b0, r_nearc, 8'b0};
    assign j_sh  = {1'b0, r_jump, 8'b0};

    always_comb begin
        if (r_win == '0)                    n_kind = HZ_NONE;
        else if (n_sh < r_pmvf)             n_kind = HZ_NO_RETURN;
        else if (f_sh >= r_phfw)            n_kind = HZ_DROP_OFF;
        else if (nr_sh >= r_phfw)           n_kind = HZ_OBSTRUCTION;
        else if ((r_valid != '0) && ((r_dev >= r_prn2) || (j_sh >= r_phfd)))
                                            n_kind = HZ_ROUGH;
        else                                n_kind = HZ_NONE;
    end

    // Divider: nine quotient bits, saturating, restoring.
    logic [XW-1:0]     div_num, r_rem, r_dsh;
    logic [PRNW-1:0]   div_den;
    logic              div_sat, ge, r_div_busy, r_sat;
    logic [3:0]        r_cnt;
    logic [QUOT_W-1:0] r_q, q9, qcap;
    t_div_sel          r_div_sel;
    logic [FRAC_W-1:0] r_cov, r_conf, r_c1;
    logic [SUMW-1:0]   r_s;

    always_comb begin
        case (i_cmd.div_sel)
            DS_COV: begin
                div_num = XW'({r_valid, 8'b0});
                div_den = PRNW'(r_win);
            end
            DS_FAR: begin
                div_num = XW'({r_far, 8'b0});
                div_den = PRNW'(r_win);
            end
            DS_NEAR: begin
                div_num = XW'({r_nearc, 8'b0});
                div_den = PRNW'(r_win);
            end
            DS_C1: begin
                div_num = XW'({r_s, 8'b0});
                div_den = r_prn;
            end
            default: begin
                div_num = XW'({r_jump, 8'b0});
                div_den = PRNW'(r_phfd);
            end
        endcase
        div_sat = (div_den == '0) || (div_num >= (XW'(div_den) << QUOT_W));
        ge      = (r_rem >= r_dsh);
        q9      = {r_q[QUOT_W-2:0], ge};
        qcap    = (r_sat || (q9 > Q8_ONE)) ? Q8_ONE : q9;
    end

    assign o_stat.div_done = r_div_busy && (r_cnt == 4'd0);

    // Square root: one result bit per cycle.
    logic [DEVW-1:0] r_v, r_res, r_bit, sq_try, n_res;
    logic            sq_ge;

    always_comb begin
        sq_try = r_res + r_bit;
        sq_ge  = (r_v >= sq_try);
        n_res  = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    assign o_stat.sqrt_done = r_bit[0];
    assign o_stat.kind      = r_kind;

    // Streak update.
    logic [CONF_W-1:0] r_hs, r_cs, n_hs, n_cs, confirm_eff;
    t_hazard           r_at, n_at;
    logic [FRAC_W-1:0] r_ac, n_ac, conf_sel;

    always_comb begin
        confirm_eff = (r_confirm == '0) ? CONF_W'(1) : r_confirm;
        conf_sel    = (r_kind == HZ_NO_RETURN) ? Q8_ONE - r_cov : r_conf;
        n_at        = r_at;
        n_ac        = r_ac;
        if (r_kind != HZ_NONE) begin
            n_hs = (r_hs == 8'hFF) ? r_hs : r_hs + 8'd1;
            n_cs = '0;
            if (n_hs >= confirm_eff) begin
                n_at = r_kind;
                n_ac = conf_sel;
            end
        end else begin
            n_hs = '0;
            n_cs = (r_cs == 8'hFF) ? r_cs : r_cs + 8'd1;
            if (n_cs >= CONF_W'(CLR_SCAN_LIMIT)) begin
                n_at = HZ_NONE;
                n_ac = '0;
            end
        end
    end

    logic [2:0]         r_o_type;
    logic               r_o_act;
    logic [FRAC_W-1:0]  r_o_conf, r_o_cov;
    logic [RANGE_W-1:0] r_o_near;

    assign o_m_tdata = {2'b0, r_o_near, r_o_cov, r_o_conf, r_o_act, r_o_type};

    // Scan accumulators and streaks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.update) begin
            r_win       <= '0;
            r_valid     <= '0;
            r_far       <= '0;
            r_nearc     <= '0;
            r_jump      <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_nearest   <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
        end else if (i_cmd.take && i_s_present && in_window) begin
            r_win <= r_win + CW'(1);
            if (in_range) begin
                r_valid <= r_valid + CW'(1);
                if ((r_valid == '0) || (s_range < r_nearest)) r_nearest <= s_range;
                if (s_range >= r_drop)     r_far   <= r_far + CW'(1);
                if (s_range <= r_near_thr) r_nearc <= r_nearc + CW'(1);
                if (is_jump)               r_jump  <= r_jump + CW'(1);
                r_prev      <= s_range;
                r_have_prev <= 1'b1;
                r_sum       <= r_sum + SUMW'(s_range);
                r_sumsq     <= r_sumsq + SQW'(r_sq_term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs <= '0;
            r_cs <= '0;
            r_at <= HZ_NONE;
            r_ac <= '0;
        end else if (i_cmd.update) begin
            r_hs <= n_hs;
            r_cs <= n_cs;
            r_at <= n_at;
            r_ac <= n_ac;
        end
    end

    // Unit control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_bit      <= '0;
        end else begin
            if (i_cmd.div_start)        r_div_busy <= 1'b1;
            else if (o_stat.div_done)   r_div_busy <= 1'b0;
            if (i_cmd.sqrt_start)       r_bit <= DEVW'(1) << (DEVW - 2);
            else                        r_bit <= r_bit >> 2;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_plo  <= r_valid * r_sumsq[LOW-1:0];
            r_phi  <= r_valid * r_sumsq[SQW-1:LOW];
            r_pss  <= r_sum * r_sum;
            r_prn  <= r_valid * r_rt;
            r_pmvf <= r_mvf * r_win;
            r_phfw <= r_hf * r_win;
            r_phfd <= r_hf * den_n;
        end
        if (i_cmd.prep2) begin
            r_dev  <= DEVW'(r_plo) + (DEVW'(r_phi) << LOW) - r_pss;
            r_prn2 <= r_prn * r_prn;
        end
        if (i_cmd.classify) r_kind <= n_kind;

        if (o_stat.div_done) begin
            case (r_div_sel) inside
                DS_COV:          r_cov  <= (r_win == '0) ? '0 : qcap;
                DS_FAR, DS_NEAR: r_conf <= qcap;
                DS_C1:           r_c1   <= qcap;
                default:         r_conf <= (r_c1 > qcap) ? r_c1 : qcap;
            endcase
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
            r_rem     <= div_num;
            r_dsh     <= XW'(div_den) << (QUOT_W - 1);
            r_sat     <= div_sat;
            r_cnt     <= div_sat ? 4'd0 : 4'(QUOT_W - 1);
            r_q       <= '0;
        end else if (r_div_busy) begin
            if (ge) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= q9;
            r_cnt <= r_cnt - 4'd1;
        end

        if (i_cmd.sqrt_start) begin
            r_v   <= r_dev;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (sq_ge) r_v <= r_v - sq_try;
            r_res <= n_res;
            if (r_bit[0]) r_s <= SUMW'(n_res);
        end

        if (i_cmd.update) begin
            r_o_type <= n_at;
            r_o_act  <= (n_at != HZ_NONE);
            r_o_conf <= (n_at != HZ_NONE) ? n_ac : '0;
            r_o_cov  <= r_cov;
            r_o_near <= (r_valid != '0) ? r_nearest : '0;
        end
    end

endmodule

>>> rtl/lidar_terrain_hazard_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_terrain_hazard_classifier
// Accumulates forward-window lidar statistics per scan and reports a
// confirmed terrain hazard at the end of every scan.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          one lidar sample or end marker
// m_axis    out        tvalid/tready          one hazard report per scan
// cfg       in         write enable only      settings registers 0..7
//
// A sample transaction is taken as soon as it is offered during intake, and
// samples may arrive back to back. A transaction with tlast starts the
// end-of-scan sequence, during which tready is low: the product and
// classification states PREP, PREP2 and CLASS, a run of the shared divider
// for coverage, another for a drop-off or obstruction confidence, and for
// rough ground one square-root step per result bit, a launch state and two
// divider runs. A divider run whose quotient saturates skips its quotient
// steps and finishes in the cycle after its launch. The UPD state then
// loads the report, which is held until the m_axis transaction completes.
// Reset is synchronous and active low; no clearing pass is needed afterwards.
module lidar_terrain_hazard_classifier
    import lthc_pkg::*;
#(
    parameter int MAX_SAMPLES    = 2048,
    parameter int MIN_RANGE_MM   = 100,
    parameter int MAX_RANGE_MM   = 12000,
    parameter int CLR_SCAN_LIMIT = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // range_mm[15:0], range_finite[16], angle_mrad[30:17], zero[31]
    input  logic [31:0]      i_s_axis_tdata,
    // sample_present[0]
    input  logic [0:0]       i_s_axis_tuser,
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // hazard kind[2:0], hazard_active[3], confidence[12:4], coverage[21:13],
    // nearest_range[37:22], zero[39:38]
    output logic [39:0]      o_m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller owns the handshakes; the datapath owns all arithmetic.
    lthc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tlast  (i_s_axis_tlast),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid)
    );

    lthc_dpath #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .MIN_RANGE_MM   (MIN_RANGE_MM),
        .MAX_RANGE_MM   (MAX_RANGE_MM),
        .CLR_SCAN_LIMIT (CLR_SCAN_LIMIT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_present (i_s_axis_tuser[0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (w_stat),
        .o_m_tdata   (o_m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // A pending report blocks new samples.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input accepted while a report is pending");

    // Once a report is taken the block returns to sample intake.
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> o_s_axis_tready)
        else $error("block did not return to intake after report");

    // No hazard means zero confidence and a clear active flag.
    a_none_zero_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[2:0] == HZ_NONE))
            |-> ((o_m_axis_tdata[12:4] == '0) && !o_m_axis_tdata[3]))
        else $error("confidence reported without a hazard");

    // Confidence never exceeds one in Q8.
    a_conf_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[12:4] <= Q8_ONE))
        else $error("confidence above cap");
`endif

endmodule
